@@ hdl/assert_macros.svh @@
// assertion macros for the parser rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define RRP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("rrp assertion failed");

// check a property on every rising edge, reset included
`define RRP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("rrp assertion failed");

`endif

@@ hdl/rrp_pkg.sv @@
// shared types and constants for the resp request parser
// no dependencies; used by every module of the parser
`timescale 1ns / 1ps

package rrp_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_END_ARG  = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_BAD_START = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
    localparam logic [2:0] ERR_NEG_LEN   = 3'd2;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    // queue between classifier and parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int ACC_W   = 31;
    localparam int ARGS_W  = 21;
    localparam int IDX_W   = 20;
    localparam int BYTES_W = 30;

    // classified input transaction
    typedef struct packed {
        logic       restart;
        logic [7:0] raw;
        logic [7:0] lower;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_lf;
        logic       is_star;
    } byte_class_t;

endpackage

@@ hdl/rrp_front.sv @@
// front end: accepts input transactions and classifies each byte
// depends on rrp_pkg
`timescale 1ns / 1ps

module rrp_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                q_full,
    output logic                q_push,
    output rrp_pkg::byte_class_t q_item
);

    logic [7:0] c;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        q_item          = '0;
        q_item.restart  = s_axis_tuser;
        q_item.raw      = c;
        q_item.lower    = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
        q_item.is_digit = (c >= 8'h30 && c <= 8'h39);
        q_item.digit    = c[3:0];
        q_item.is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) ||
                          (c == 8'h0C) || (c == 8'h0D);
        q_item.is_sign  = (c == 8'h2B) || (c == 8'h2D);
        q_item.is_minus = (c == 8'h2D);
        q_item.is_lf    = (c == 8'h0A);
        q_item.is_star  = (c == 8'h2A);
    end

endmodule

@@ hdl/rrp_queue.sv @@
// short fifo of classified bytes between front end and parser
// depends on rrp_pkg
`timescale 1ns / 1ps

module rrp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rrp_pkg::byte_class_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output rrp_pkg::byte_class_t pop_item
);

    rrp_pkg::byte_class_t           slot_reg [rrp_pkg::QUEUE_DEPTH];
    logic [rrp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rrp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rrp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign full      = (count_reg == rrp_pkg::QCNT_W'(rrp_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/rrp_back.sv @@
// parser back end: phase machine, header number reader and result register
// depends on rrp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  rrp_pkg::byte_class_t          q_item,
    output logic                          q_pop,
    input  logic [rrp_pkg::ARGS_W-1:0]    max_args,
    input  logic [rrp_pkg::BYTES_W-1:0]   max_arg_len,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser
);

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_COUNT     = 3'd1;
    localparam logic [2:0] PH_LEN_FIRST = 3'd2;
    localparam logic [2:0] PH_LEN       = 3'd3;
    localparam logic [2:0] PH_DATA      = 3'd4;
    localparam logic [2:0] PH_TRAIL1    = 3'd5;
    localparam logic [2:0] PH_TRAIL2    = 3'd6;

    localparam logic [1:0] HS_PRE    = 2'd0;
    localparam logic [1:0] HS_SIGNED = 2'd1;
    localparam logic [1:0] HS_DIGITS = 2'd2;
    localparam logic [1:0] HS_SKIP   = 2'd3;

    localparam int WIDE_W = rrp_pkg::ACC_W + 4;

    logic [2:0]                   phase_reg, phase_next;
    logic [1:0]                   hstage_reg, hstage_next;
    logic [rrp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                         neg_reg, neg_next;
    logic [rrp_pkg::ARGS_W-1:0]   args_left_reg, args_left_next;
    logic [rrp_pkg::IDX_W-1:0]    index_reg, index_next;
    logic [rrp_pkg::BYTES_W-1:0]  bytes_left_reg, bytes_left_next;
    logic                         err_reg, err_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [7:0]                   data_reg, data_next;
    logic [7:0]                   lower_reg, lower_next;
    logic [rrp_pkg::IDX_W-1:0]    oidx_reg, oidx_next;
    logic [2:0]                   code_reg, code_next;

    logic                         take, load;
    logic [WIDE_W-1:0]            acc_wide;
    logic [rrp_pkg::ACC_W-1:0]    acc_sat;
    logic                         line_neg;
    logic [rrp_pkg::BYTES_W-1:0]  bytes_dec;
    logic [rrp_pkg::ARGS_W-1:0]   args_dec;

    assign take  = q_valid && (!out_valid_reg || m_axis_tready);
    assign q_pop = take;

    // saturating decimal accumulate
    assign acc_wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                    + {{(WIDE_W-4){1'b0}}, q_item.digit};
    assign acc_sat  = (acc_wide > {4'd0, {rrp_pkg::ACC_W{1'b1}}})
                    ? {rrp_pkg::ACC_W{1'b1}} : acc_wide[rrp_pkg::ACC_W-1:0];
    assign line_neg  = neg_reg && (acc_reg != '0);
    assign bytes_dec = bytes_left_reg - 1'b1;
    assign args_dec  = args_left_reg - 1'b1;

    always_comb begin
        logic [1:0] stg;
        logic       skip;

        phase_next      = phase_reg;
        hstage_next     = hstage_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        args_left_next  = args_left_reg;
        index_next      = index_reg;
        bytes_left_next = bytes_left_reg;
        err_next        = err_reg;
        load            = 1'b0;
        kind_next       = kind_reg;
        data_next       = data_reg;
        lower_next      = lower_reg;
        oidx_next       = oidx_reg;
        code_next       = code_reg;
        stg             = hstage_reg;
        skip            = 1'b0;

        if (take) begin
            if (q_item.restart) begin
                phase_next      = PH_START;
                hstage_next     = HS_PRE;
                acc_next        = '0;
                neg_next        = 1'b0;
                args_left_next  = '0;
                index_next      = '0;
                bytes_left_next = '0;
                err_next        = 1'b0;
            end else if (!err_reg) begin
                kind_next  = rrp_pkg::KIND_DATA;
                data_next  = '0;
                lower_next = '0;
                oidx_next  = index_reg;
                code_next  = rrp_pkg::ERR_BAD_START;
                case (phase_reg)
                    PH_START: begin
                        if (!q_item.is_star) begin
                            load      = 1'b1;
                            err_next  = 1'b1;
                            kind_next = rrp_pkg::KIND_ERROR;
                            code_next = rrp_pkg::ERR_BAD_START;
                        end else begin
                            phase_next  = PH_COUNT;
                            hstage_next = HS_PRE;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                        end
                    end
                    PH_LEN_FIRST: begin
                        hstage_next = HS_PRE;
                        acc_next    = '0;
                        neg_next    = 1'b0;
                        if (q_item.is_lf) begin
                            // empty length line: zero-length argument
                            bytes_left_next = '0;
                            phase_next      = PH_TRAIL1;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_COUNT, PH_LEN: begin
                        if (!q_item.is_lf) begin
                            if (stg == HS_PRE) begin
                                if (q_item.is_space) begin
                                    skip = 1'b1;
                                end else if (q_item.is_sign) begin
                                    neg_next = q_item.is_minus;
                                    stg      = HS_SIGNED;
                                    skip     = 1'b1;
                                end else begin
                                    stg = q_item.is_digit ? HS_DIGITS : HS_SKIP;
                                end
                            end else if (stg == HS_SIGNED) begin
                                stg = q_item.is_digit ? HS_DIGITS : HS_SKIP;
                            end else if (stg == HS_DIGITS && !q_item.is_digit) begin
                                stg = HS_SKIP;
                            end
                            hstage_next = stg;
                            if (!skip && stg == HS_DIGITS) begin
                                acc_next = acc_sat;
                            end
                        end else begin
                            hstage_next = HS_PRE;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            if (phase_reg == PH_COUNT) begin
                                if (line_neg || acc_reg == '0) begin
                                    load      = 1'b1;
                                    err_next  = 1'b1;
                                    kind_next = rrp_pkg::KIND_ERROR;
                                    code_next = rrp_pkg::ERR_BAD_COUNT;
                                end else if (acc_reg > {10'd0, max_args}) begin
                                    load      = 1'b1;
                                    err_next  = 1'b1;
                                    kind_next = rrp_pkg::KIND_ERROR;
                                    code_next = rrp_pkg::ERR_TOO_MANY;
                                end else begin
                                    args_left_next = acc_reg[rrp_pkg::ARGS_W-1:0];
                                    index_next     = '0;
                                    phase_next     = PH_LEN_FIRST;
                                end
                            end else begin
                                if (line_neg) begin
                                    load      = 1'b1;
                                    err_next  = 1'b1;
                                    kind_next = rrp_pkg::KIND_ERROR;
                                    code_next = rrp_pkg::ERR_NEG_LEN;
                                end else if (acc_reg > {1'b0, max_arg_len}) begin
                                    load      = 1'b1;
                                    err_next  = 1'b1;
                                    kind_next = rrp_pkg::KIND_ERROR;
                                    code_next = rrp_pkg::ERR_TOO_LONG;
                                end else begin
                                    bytes_left_next = acc_reg[rrp_pkg::BYTES_W-1:0];
                                    phase_next = (acc_reg != '0) ? PH_DATA : PH_TRAIL1;
                                end
                            end
                        end
                    end
                    PH_DATA: begin
                        load            = 1'b1;
                        kind_next       = rrp_pkg::KIND_DATA;
                        data_next       = q_item.raw;
                        lower_next      = (index_reg == '0) ? q_item.lower : 8'd0;
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == '0) begin
                            phase_next = PH_TRAIL1;
                        end
                    end
                    PH_TRAIL1: begin
                        load       = 1'b1;
                        kind_next  = rrp_pkg::KIND_END_ARG;
                        phase_next = PH_TRAIL2;
                    end
                    PH_TRAIL2: begin
                        args_left_next = args_dec;
                        if (args_dec == '0) begin
                            load       = 1'b1;
                            kind_next  = rrp_pkg::KIND_COMPLETE;
                            phase_next = PH_START;
                        end else begin
                            index_next = index_reg + 1'b1;
                            phase_next = PH_LEN_FIRST;
                        end
                    end
                    default: begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            hstage_reg     <= HS_PRE;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            args_left_reg  <= '0;
            index_reg      <= '0;
            bytes_left_reg <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hstage_reg     <= hstage_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            args_left_reg  <= args_left_next;
            index_reg      <= index_next;
            bytes_left_reg <= bytes_left_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            lower_reg <= lower_next;
            oidx_reg  <= oidx_next;
            code_reg  <= code_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {1'b0, code_reg, oidx_reg, lower_reg, data_reg};

    `RRP_ASSERT(a_no_load_when_latched, aclk, aresetn, load |-> !err_reg)
    `RRP_ASSERT(a_data_has_bytes, aclk, aresetn,
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
    `RRP_ASSERT(a_trail_has_args, aclk, aresetn,
        (phase_reg == PH_TRAIL2 || phase_reg == PH_DATA) |-> args_left_reg != '0)
    `RRP_ASSERT(a_held_result_kept, aclk, aresetn,
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(kind_reg))

endmodule

@@ hdl/resp_request_parser.sv @@
// top level of the resp request array parser: config registers and wiring
// depends on rrp_pkg, rrp_front, rrp_queue, rrp_back
//
// channel   | direction | handshake              | payload
// s_axis    | in        | tvalid / tready        | tdata: stream_byte; tuser: op
// m_axis    | out       | tvalid / tready        | tdata: data, lower, index, code
// apb       | in        | psel / penable / pready| max_args at 0x0, max_arg_len at 0x4
//
// one byte per cycle sustained while m_axis takes results; an accepted byte
// waits in the queue stage, and any result it makes is held in the result register
// a four-entry queue keeps accepting while a result waits on m_axis
// aresetn is synchronous and active low; no clearing pass is needed
`timescale 1ns / 1ps

module resp_request_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [15:8] lower_byte,
                                        // [35:16] arg_index, [38:36] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [rrp_pkg::ARGS_W-1:0]  max_args_reg;
    logic [rrp_pkg::BYTES_W-1:0] max_arg_len_reg;
    logic                        cfg_write;
    logic                        q_full, q_push, q_pop, q_valid;
    rrp_pkg::byte_class_t        push_item, pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_args_reg    <= rrp_pkg::ARGS_W'(1024);
            max_arg_len_reg <= rrp_pkg::BYTES_W'(536870912);
        end else if (cfg_write) begin
            if (paddr[2]) begin
                max_arg_len_reg <= pwdata[rrp_pkg::BYTES_W-1:0];
            end else begin
                max_args_reg <= pwdata[rrp_pkg::ARGS_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {11'd0, max_args_reg};
            default: prdata = {2'd0, max_arg_len_reg};
        endcase
    end

    rrp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    rrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    rrp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .max_args      (max_args_reg),
        .max_arg_len   (max_arg_len_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
